// File: design/dq_pkg.sv
package dq_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FRONT = 3'd4,
    OP_READ_BACK  = 3'd5,
    OP_STATUS     = 3'd6
  } dq_op_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // capture opcode and record
    logic exec;     // update pointers/count, touch one memory entry
    logic respond;  // present the result for one cycle
  } dq_cmd_t;

endpackage

// File: design/dq_ctrl.sv
module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output dq_pkg::dq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/dq_datapath.sv
module dq_datapath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dq_pkg::dq_cmd_t              cmd_i,
  input  logic [dq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [dq_pkg::ITEM_W-1:0]    item_data_i,
  output logic                         ok_o,
  output logic [dq_pkg::ITEM_W-1:0]    read_data_o,
  output logic [dq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                         is_empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [dq_pkg::OPCODE_W-1:0] op_q;
  logic [DATA_WIDTH-1:0]       rec_q;
  logic [PTR_W-1:0]            front_q, front_d, back_q, back_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        ok_q, ok_d;
  logic                        rd_sel_q, rd_sel_d;
  logic [DATA_WIDTH-1:0]       rd_q;

  logic                        wr_en;
  logic [PTR_W-1:0]            wr_addr, rd_addr;
  logic [PTR_W-1:0]            front_prev, front_next, back_prev, back_next;
  logic                        full, empty;
  logic [DATA_WIDTH+dq_pkg::ITEM_W-1:0] item_ext, rd_ext;
  logic [CNT_W+dq_pkg::COUNT_W-1:0]     cnt_ext;

  // keep the low DATA_WIDTH bits of the record, zero-fill if wider
  assign item_ext = {{DATA_WIDTH{1'b0}}, item_data_i};

  assign full  = (count_q == FULL);
  assign empty = (count_q == '0);

  assign front_prev = (front_q == '0)  ? LAST : front_q - 1'b1;
  assign front_next = (front_q == LAST) ? '0  : front_q + 1'b1;
  assign back_prev  = (back_q == '0)   ? LAST : back_q - 1'b1;
  assign back_next  = (back_q == LAST)  ? '0  : back_q + 1'b1;

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    ok_d     = 1'b0;
    rd_sel_d = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    case (dq_pkg::dq_op_e'(op_q))
      dq_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          front_d = front_prev;
          wr_addr = front_prev;
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          wr_addr = back_q;
          wr_en   = 1'b1;
          back_d  = back_next;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          front_d = front_next;
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (!empty) begin
          back_d  = back_prev;
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
        end
      end
      dq_pkg::OP_READ_FRONT: begin
        rd_addr = front_q;
        if (!empty) begin
          rd_sel_d = 1'b1;
          ok_d     = 1'b1;
        end
      end
      dq_pkg::OP_READ_BACK: begin
        rd_addr = back_prev;
        if (!empty) begin
          rd_sel_d = 1'b1;
          ok_d     = 1'b1;
        end
      end
      dq_pkg::OP_STATUS: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // ring storage: one write or one registered read per operation
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= rec_q;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      rec_q <= item_ext[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      ok_q     <= 1'b0;
      rd_sel_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      ok_q     <= ok_d;
      rd_sel_q <= rd_sel_d;
    end
  end

  assign rd_ext  = {{dq_pkg::ITEM_W{1'b0}}, (rd_sel_q ? rd_q : '0)};
  assign cnt_ext = {{dq_pkg::COUNT_W{1'b0}}, count_q};

  assign ok_o          = ok_q;
  assign read_data_o   = rd_ext[dq_pkg::ITEM_W-1:0];
  assign entry_count_o = cnt_ext[dq_pkg::COUNT_W-1:0];
  assign is_empty_o    = empty;

endmodule

// File: design/double_ended_queue_core.sv
// Bounded double-ended queue of DEPTH records, DATA_WIDTH bits each, kept
// in a ring with front/back pointers and an occupancy count.
//
// Command channel: drive opcode_i/item_data_i with start high; the
// transfer happens on a rising edge where start is high and busy low.
// Opcodes: push front/back, pop front/back, read front/back, status.
//
// Result channel: done_o pulses for one cycle with ok_o, read_data_o,
// entry_count_o and is_empty_o. The receiver cannot stall; the result must
// be taken in that cycle.
//
// Timing: accept edge -> execute cycle (pointer/count update and one
// memory access, read data registered) -> result cycle with done_o high.
// busy is high for both, so no new command is taken before the result
// cycle ends; the ring memory port and its registered read set this sequence.
//
// Reset (rst_ni low, async) clears pointers and count; the deque is empty.
// The ring memory is not cleared: only pushed entries are ever read.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [dq_pkg::ITEM_W-1:0]    item_data_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic [dq_pkg::ITEM_W-1:0]    read_data_o,
  output logic [dq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                         is_empty_o
);

  dq_pkg::dq_cmd_t cmd;

  // sequencer: idle -> exec -> resp
  dq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  // ring storage, pointers, count and result registers
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .item_data_i   (item_data_i),
    .ok_o          (ok_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  // result strobe lines up with the registered result fields
  assign done_o = cmd.respond;

endmodule

// File: tb/sv/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [dq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [dq_pkg::ITEM_W-1:0]    item_data_i,
  input  logic                         done_i,
  input  logic                         ok_i,
  input  logic [dq_pkg::ITEM_W-1:0]    read_data_i,
  input  logic [dq_pkg::COUNT_W-1:0]   entry_count_i,
  input  logic                         is_empty_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import dq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ITEM_W-1:0] REC_MASK = {ITEM_W{1'b1}} >> (ITEM_W - DATA_WIDTH);

  typedef struct packed {
    logic               ok;
    logic [ITEM_W-1:0]  read_data;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } deque_result_t;

  // shadow deque
  logic [ITEM_W-1:0]  ring_mem [DEPTH];
  logic [PTR_W-1:0]   front_idx;
  logic [PTR_W-1:0]   back_idx;
  logic [COUNT_W-1:0] held;

  deque_result_t expected_results[$];
  deque_result_t got, want;

  function automatic logic [PTR_W-1:0] ring_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_dec(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  task automatic apply_deque_op(input dq_op_e op, input logic [ITEM_W-1:0] rec,
                                output deque_result_t res);
    logic is_full;
    logic is_void;
    is_full = (held >= COUNT_W'(DEPTH));
    is_void = (held == '0);
    res = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (!is_full) begin
          front_idx = ring_dec(front_idx);
          ring_mem[front_idx] = rec & REC_MASK;
          held = held + 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (!is_full) begin
          ring_mem[back_idx] = rec & REC_MASK;
          back_idx = ring_inc(back_idx);
          held = held + 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (!is_void) begin
          front_idx = ring_inc(front_idx);
          held = held - 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (!is_void) begin
          back_idx = ring_dec(back_idx);
          held = held - 1'b1;
          res.ok = 1'b1;
        end
      end
      OP_READ_FRONT: begin
        if (!is_void) begin
          res.read_data = ring_mem[front_idx];
          res.ok = 1'b1;
        end
      end
      OP_READ_BACK: begin
        if (!is_void) begin
          res.read_data = ring_mem[ring_dec(back_idx)];
          res.ok = 1'b1;
        end
      end
      OP_STATUS: res.ok = 1'b1;
      default: res.ok = 1'b0;  // unused code: no effect
    endcase
    res.entry_count = held;
    res.is_empty = (held == '0);
  endtask

  task automatic check_field(input string name, input logic [ITEM_W-1:0] exp_v,
                             input logic [ITEM_W-1:0] act_v);
    if (act_v !== exp_v) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    front_idx = '0;
    back_idx = '0;
    held = '0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      front_idx = '0;
      back_idx = '0;
      held = '0;
      expected_results.delete();
    end else begin
      // result first: a transfer on this edge cannot be answered on it
      if (done_i) begin
        got = '{ok_i, read_data_i, entry_count_i, is_empty_i};
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no command outstanding, actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("ok", ITEM_W'(want.ok), ITEM_W'(got.ok));
          check_field("read_data", want.read_data, got.read_data);
          check_field("entry_count", ITEM_W'(want.entry_count), ITEM_W'(got.entry_count));
          check_field("is_empty", ITEM_W'(want.is_empty), ITEM_W'(got.is_empty));
        end
      end
      if (start_i && !busy_i) begin
        apply_deque_op(dq_op_e'(opcode_i), item_data_i, want);
        expected_results.push_back(want);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: tb/sv/double_ended_queue_core_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  // transfers plus random gaps stay far below this
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RAND_BLOCKS = 14;
  localparam int unsigned BLOCK_LEN = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [OPCODE_W-1:0] opcode_i;
  logic [ITEM_W-1:0]   item_data_i;
  logic                done_o;
  logic                ok_o;
  logic [ITEM_W-1:0]   read_data_o;
  logic [COUNT_W-1:0]  entry_count_o;
  logic                is_empty_o;

  int fail_count;
  int pending;
  bit gaps_on;  // cleared for the stretch with back-to-back transfers

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .item_data_i   (item_data_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  // Watches both channels, keeps the shadow deque and scores results.
  dq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode_i),
    .item_data_i   (item_data_i),
    .done_i        (done_o),
    .ok_i          (ok_o),
    .read_data_i   (read_data_o),
    .entry_count_i (entry_count_o),
    .is_empty_i    (is_empty_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang guard: nothing follows the $finish in this process.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("double_ended_queue_core verification failed");
    $finish;
  end

  // One command transfer. Inputs move on the falling edge; the transfer
  // is taken on the first rising edge with busy low. start gets one
  // assignment per falling edge, so a held start never glitches.
  task automatic send_cmd(input dq_op_e op, input logic [ITEM_W-1:0] data);
    while (gaps_on && $urandom_range(0, 99) < 18) begin
      @(negedge clk_i);
      start = 1'b0;
      opcode_i = OPCODE_W'($urandom_range(0, 6));
      item_data_i = $urandom;
    end
    @(negedge clk_i);
    start = 1'b1;
    opcode_i = op;
    item_data_i = data;
    do @(posedge clk_i); while (busy);
  endtask

  // Sender backs off until every outstanding result has come home.
  task automatic quiesce();
    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [ITEM_W-1:0] pick_record();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  // Opcode mix by phase: 0 fill, 2 drain, otherwise uniform.
  function automatic dq_op_e pick_op(int unsigned phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      0: begin
        if (r < 40) return OP_PUSH_FRONT;
        if (r < 80) return OP_PUSH_BACK;
        if (r < 85) return OP_POP_FRONT;
        if (r < 90) return OP_POP_BACK;
        return dq_op_e'(OPCODE_W'($urandom_range(4, 6)));
      end
      2: begin
        if (r < 35) return OP_POP_FRONT;
        if (r < 70) return OP_POP_BACK;
        if (r < 76) return OP_PUSH_FRONT;
        if (r < 82) return OP_PUSH_BACK;
        return dq_op_e'(OPCODE_W'($urandom_range(4, 6)));
      end
      default: return dq_op_e'(OPCODE_W'($urandom_range(0, 6)));
    endcase
  endfunction

  initial begin
    start = 1'b0;
    opcode_i = OP_STATUS;
    item_data_i = '0;
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every opcode but push back on an empty deque, then the data extremes,
    // front/back aliasing on one record, and draining back to empty.
    send_cmd(OP_STATUS, '0);
    send_cmd(OP_POP_FRONT, '0);
    send_cmd(OP_POP_BACK, '1);
    send_cmd(OP_READ_FRONT, '0);
    send_cmd(OP_READ_BACK, '1);
    send_cmd(OP_PUSH_FRONT, '0);
    send_cmd(OP_READ_FRONT, '1);
    send_cmd(OP_READ_BACK, '1);
    send_cmd(OP_PUSH_BACK, '1);
    send_cmd(OP_READ_BACK, '0);
    send_cmd(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_cmd(OP_READ_FRONT, '0);
    send_cmd(OP_STATUS, '1);
    send_cmd(OP_POP_FRONT, '1);
    send_cmd(OP_POP_BACK, '0);
    send_cmd(OP_READ_FRONT, '0);
    send_cmd(OP_POP_FRONT, '1);
    send_cmd(OP_POP_BACK, '1);
    send_cmd(OP_STATUS, '0);

    // Random: phases alternate fill / mixed / drain / mixed, so both the
    // full and empty boundaries are hit many times with random content.
    for (int unsigned blk = 0; blk < RAND_BLOCKS; blk++) begin
      for (int unsigned k = 0; k < BLOCK_LEN; k++) begin
        gaps_on = !(blk >= 5 && blk < 8);
        if ((blk == 3 || blk == 10) && k == 0) quiesce();
        send_cmd(pick_op(blk % 4), pick_record());
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("double_ended_queue_core verification clean");
    end else begin
      $display("double_ended_queue_core verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue_core.sv
tb/sv/dq_checker.sv
tb/sv/double_ended_queue_core_tb.sv
